/* src/fbsf_pkg.sv */
// Package for the frame buffer shape fill block: opcodes, register map,
// controller/datapath command and status types, coordinate clamp helper.
// No dependencies; the core, register block, sequencer, datapath and bench import it.
package fbsf_pkg;

   // drawing command opcodes
   localparam logic [2:0] OP_FILL   = 3'd0;
   localparam logic [2:0] OP_CLEAR  = 3'd1;
   localparam logic [2:0] OP_PIXEL  = 3'd2;
   localparam logic [2:0] OP_RECT   = 3'd3;
   localparam logic [2:0] OP_CIRCLE = 3'd4;
   localparam logic [2:0] OP_READ   = 3'd5;

   // scan kinds of the walk engine
   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_RECT  = 2'd1;
   localparam logic [1:0] KIND_CIRC  = 2'd2;
   localparam logic [1:0] KIND_POINT = 2'd3;

   // register map: index is paddr[2]
   localparam int         CSR_ADDR_W = 3;
   localparam int         CSR_DATA_W = 32;
   localparam int         SIZE_W     = 7;
   localparam logic       CSR_WIDTH  = 1'b0;
   localparam logic       CSR_HEIGHT = 1'b1;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

   localparam int         COORD_W      = 13;
   localparam int         RADIUS_W     = 7;
   localparam int         PIXEL_W      = 32;
   localparam logic [PIXEL_W-1:0] MAGENTA = 32'h00ff00ff;

   typedef struct packed {
      logic load;     // latch the accepted item
      logic prep;     // clamp bounds, square the radius
      logic start;    // seed the walk counters
      logic scan;     // emit one pixel and advance
      logic init;     // qualifies prep: clearing pass after reset
      logic respond;  // load the result register
   } fbsf_cmd_type;

   typedef struct packed {
      logic empty;    // nothing to walk
      logic last;     // current scan step is the final one
      logic busy;     // write/read pipeline still in flight
      logic rsp_full; // result register occupied and not taken this cycle
   } fbsf_stat_type;

   // clamp a signed coordinate to 0..hi
   function automatic logic [COORD_W-1:0] clamp_coord(input logic signed [COORD_W:0] v,
                                                      input logic [COORD_W-1:0] hi);
      logic [COORD_W-1:0] res;
      if (v[COORD_W]) begin
         res = '0;
      end else if (v[COORD_W-1:0] > hi) begin
         res = hi;
      end else begin
         res = v[COORD_W-1:0];
      end
      return res;
   endfunction

endpackage

/* src/fbsf_req_if.sv */
// Command channel of the frame buffer shape fill block: valid/ready plus
// one drawing command. No dependencies.
interface fbsf_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         opcode;
   logic signed [12:0] first_x;
   logic signed [12:0] first_y;
   logic signed [12:0] second_x;
   logic signed [12:0] second_y;
   logic [6:0]         radius;
   logic [31:0]        paint_colour;

   modport source (output valid, opcode, first_x, first_y, second_x, second_y, radius,
                   paint_colour, input ready);
   modport sink   (input valid, opcode, first_x, first_y, second_x, second_y, radius,
                   paint_colour, output ready);
endinterface

/* src/fbsf_rsp_if.sv */
// Result channel of the frame buffer shape fill block: valid/ready plus
// read data and read flag. No dependencies.
interface fbsf_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] read_colour;
   logic        is_read;

   modport source (output valid, read_colour, is_read, input ready);
   modport sink   (input valid, read_colour, is_read, output ready);
endinterface

/* src/framebuffer_shape_fill_core.sv */
// Frame buffer shape fill: a MAX_WIDTH x MAX_HEIGHT store of 32-bit pixels
// drawn by commands on req_ch; one result per command on rsp_ch.
//
// Commands: fill all, clear to magenta, write a pixel, fill a rectangle,
// fill a circle, read a pixel. Single and circle pixels clamp to the edge;
// rectangle corners clamp to 0..size. Width and height are set over the
// APB-style port (register 0 at byte 0, register 1 at byte 4); the user
// must write them only while idle, the block does not enforce it. One
// command is worked on at a time; req_ch.ready is high between commands
// and the result turns valid in the cycle that ready rises again. The
// pixel store has a single write port (one pixel a cycle); each command
// also passes through load, setup and pipeline drain.
// Reset (synchronous) runs a clearing pass that writes magenta everywhere;
// no command is taken meanwhile.
// The result sits in an output register; a new command is taken while it
// waits, but the next result holds back until the receiver takes it.
// Depends on fbsf_pkg, fbsf_req_if, fbsf_rsp_if, fbsf_csr, fbsf_ctrl,
// fbsf_datapath and fbsf_ram.
module framebuffer_shape_fill_core #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   fbsf_req_if.sink                            req_ch,
   fbsf_rsp_if.source                          rsp_ch,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [fbsf_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [fbsf_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [fbsf_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);
   import fbsf_pkg::*;

   localparam int XW = $clog2(MAX_WIDTH + 1);
   localparam int YW = $clog2(MAX_HEIGHT + 1);

   logic [XW-1:0]  w_eff;
   logic [YW-1:0]  h_eff;
   fbsf_cmd_type   cmd;
   fbsf_stat_type  stat;

   fbsf_csr #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .w_eff   (w_eff),
      .h_eff   (h_eff)
   );

   fbsf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   fbsf_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .w_eff        (w_eff),
      .h_eff        (h_eff),
      .opcode       (req_ch.opcode),
      .first_x      (req_ch.first_x),
      .first_y      (req_ch.first_y),
      .second_x     (req_ch.second_x),
      .second_y     (req_ch.second_y),
      .radius       (req_ch.radius),
      .paint_colour (req_ch.paint_colour),
      .rsp_valid    (rsp_ch.valid),
      .rsp_ready    (rsp_ch.ready),
      .read_colour  (rsp_ch.read_colour),
      .is_read      (rsp_ch.is_read)
   );

   // an item is only taken once the previous one has left the pipeline
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |-> !stat.busy)
      else $error("item accepted while pixel pipeline busy");

   a_respond_safe: assert property (@(posedge clock) disable iff (reset)
      cmd.respond |-> !stat.busy && !stat.rsp_full)
      else $error("result loaded over a pending result or before drain");

   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.prep, cmd.start, cmd.scan, cmd.respond}))
      else $error("more than one sequencer command at once");

   a_zero_unless_read: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.is_read |-> rsp_ch.read_colour == '0)
      else $error("non-read result carries pixel data");
endmodule

/* src/fbsf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the pixel store.
module fbsf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= store_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

/* src/fbsf_csr.sv */
// APB-style register block: buffer width and height, with the sizes in
// use clamped to 1..MAX. Depends on fbsf_pkg.
module fbsf_csr #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64,
   localparam int XW = $clog2(MAX_WIDTH + 1),
   localparam int YW = $clog2(MAX_HEIGHT + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [fbsf_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [fbsf_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [fbsf_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready,
   output logic [XW-1:0]                       w_eff,
   output logic [YW-1:0]                       h_eff
);
   import fbsf_pkg::*;

   logic [SIZE_W-1:0] width_ff, width_in;
   logic [SIZE_W-1:0] height_ff, height_in;
   logic              reg_sel;
   logic              wr_en;

   assign pready  = 1'b1;
   assign reg_sel = paddr[2];
   assign wr_en   = psel && penable && pwrite;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (wr_en) begin
         unique case (reg_sel)
            CSR_WIDTH:  width_in  = pwdata[SIZE_W-1:0];
            CSR_HEIGHT: height_in = pwdata[SIZE_W-1:0];
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SIZE_RESET;
         height_ff <= SIZE_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         CSR_WIDTH:  prdata = CSR_DATA_W'(width_ff);
         CSR_HEIGHT: prdata = CSR_DATA_W'(height_ff);
         default:    prdata = '0;
      endcase
   end

   // zero acts as one, anything above the store size acts as the maximum
   always_comb begin
      if (width_ff == '0) begin
         w_eff = XW'(1);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         w_eff = XW'(MAX_WIDTH);
      end else begin
         w_eff = XW'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = YW'(1);
      end else if (int'(height_ff) > MAX_HEIGHT) begin
         h_eff = YW'(MAX_HEIGHT);
      end else begin
         h_eff = YW'(height_ff);
      end
   end
endmodule

/* src/fbsf_ctrl.sv */
// Sequencer of the frame buffer shape fill block: clearing pass after
// reset, then load, prepare, walk, drain and respond per item.
// Depends on fbsf_pkg.
module fbsf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  fbsf_pkg::fbsf_stat_type stat,
   output fbsf_pkg::fbsf_cmd_type  cmd
);
   import fbsf_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PREP  = 3'd1;
   localparam logic [2:0] ST_START = 3'd2;
   localparam logic [2:0] ST_SCAN  = 3'd3;
   localparam logic [2:0] ST_DRAIN = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       init_ff, init_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      init_in  = init_ff;
      cmd      = '0;
      cmd.init = init_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_START;
         end
         ST_START: begin
            cmd.start = 1'b1;
            state_in  = stat.empty ? ST_DRAIN : ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // wait for the last write or read to leave the pipeline
            if (!stat.busy) begin
               if (init_ff) begin
                  init_in  = 1'b0;
                  state_in = ST_IDLE;
               end else if (!stat.rsp_full) begin
                  cmd.respond = 1'b1;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_PREP;
         init_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         init_ff  <= init_in;
      end
   end
endmodule

/* src/fbsf_datapath.sv */
// Datapath of the frame buffer shape fill block: command registers, bound
// clamps, rectangle and circle walk counters, address pipeline, pixel store
// and result register. Depends on fbsf_pkg and fbsf_ram.
module fbsf_datapath #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64,
   localparam int XW = $clog2(MAX_WIDTH + 1),
   localparam int YW = $clog2(MAX_HEIGHT + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  fbsf_pkg::fbsf_cmd_type  cmd,
   output fbsf_pkg::fbsf_stat_type stat,
   input  logic [XW-1:0]           w_eff,
   input  logic [YW-1:0]           h_eff,
   input  logic [2:0]              opcode,
   input  logic signed [12:0]      first_x,
   input  logic signed [12:0]      first_y,
   input  logic signed [12:0]      second_x,
   input  logic signed [12:0]      second_y,
   input  logic [6:0]              radius,
   input  logic [31:0]             paint_colour,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [31:0]             read_colour,
   output logic                    is_read
);
   import fbsf_pkg::*;

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PW    = XW + YW;

   // latched item
   logic [2:0]                op_ff;
   logic signed [COORD_W-1:0] fx_ff, fy_ff, sx_ff, sy_ff;
   logic [RADIUS_W-1:0]       r_ff;
   logic [PIXEL_W-1:0]        colour_ff;

   // prepared bounds
   logic [1:0]        kind_ff;
   logic              rd_ff;
   logic              init_mode_ff;
   logic [XW-1:0]     x0_ff, x1_ff;
   logic [YW-1:0]     y0_ff, y1_ff;
   logic [13:0]       rr_ff;

   // walk counters
   logic [XW-1:0]     x_ff;
   logic [YW-1:0]     y_ff;
   logic signed [7:0] dx_ff, dy_ff;
   logic [13:0]       dx2_ff, dy2_ff, lim_ff;

   // address pipeline
   logic              p1_v_ff, p1_rd_ff;
   logic [XW-1:0]     p1_x_ff;
   logic [YW-1:0]     p1_y_ff;
   logic              p2_v_ff, p2_rd_ff;
   logic [AW-1:0]     p2_addr_ff;
   logic              rdv_ff;
   logic [PIXEL_W-1:0] rd_data_ff;
   logic [PIXEL_W-1:0] ram_rdata;

   // result register
   logic               rsp_valid_ff;
   logic [PIXEL_W-1:0] read_colour_ff;
   logic               is_read_ff;

   logic [COORD_W-1:0] w13, h13;
   logic [COORD_W-1:0] cl_x0, cl_x1, cl_y0, cl_y1;
   logic signed [7:0]  r_s;
   logic [XW-1:0]      x_inc;
   logic [YW-1:0]      y_inc;
   logic               x_wrap;
   logic               dx_end;
   logic [15:0]        dx2_step, dy2_step;
   logic [14:0]        sq_sum;
   logic               hit;
   logic signed [COORD_W:0] cx_sum, cy_sum;
   logic [XW-1:0]      pt_x;
   logic [YW-1:0]      pt_y;
   logic               pt_valid;
   logic [XW-1:0]      w_sel;
   logic [PW-1:0]      row_base;
   logic [AW-1:0]      pix_addr;

   assign w13   = COORD_W'(w_eff);
   assign h13   = COORD_W'(h_eff);
   assign cl_x0 = clamp_coord({fx_ff[COORD_W-1], fx_ff}, w13);
   assign cl_x1 = clamp_coord({sx_ff[COORD_W-1], sx_ff}, w13);
   assign cl_y0 = clamp_coord({fy_ff[COORD_W-1], fy_ff}, h13);
   assign cl_y1 = clamp_coord({sy_ff[COORD_W-1], sy_ff}, h13);
   assign r_s   = signed'({1'b0, r_ff});

   // latch the item; clear uses the fixed colour
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= opcode;
         fx_ff     <= first_x;
         fy_ff     <= first_y;
         sx_ff     <= second_x;
         sy_ff     <= second_y;
         r_ff      <= radius;
         colour_ff <= (opcode == OP_CLEAR) ? MAGENTA : paint_colour;
      end else if (cmd.prep && cmd.init) begin
         colour_ff <= MAGENTA;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_mode_ff <= 1'b1;
      end else if (cmd.prep) begin
         init_mode_ff <= cmd.init;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         rr_ff   <= 14'(r_ff) * 14'(r_ff);
         rd_ff   <= !cmd.init && (op_ff == OP_READ);
         kind_ff <= KIND_NONE;
         x0_ff   <= '0;
         x1_ff   <= '0;
         y0_ff   <= '0;
         y1_ff   <= '0;
         if (cmd.init) begin
            // clearing pass sweeps the whole store
            kind_ff <= KIND_RECT;
            x1_ff   <= XW'(MAX_WIDTH);
            y1_ff   <= YW'(MAX_HEIGHT);
         end else begin
            unique case (op_ff) inside
               OP_FILL, OP_CLEAR: begin
                  kind_ff <= KIND_RECT;
                  x1_ff   <= w_eff;
                  y1_ff   <= h_eff;
               end
               OP_RECT: begin
                  kind_ff <= KIND_RECT;
                  x0_ff   <= XW'(cl_x0);
                  x1_ff   <= XW'(cl_x1);
                  y0_ff   <= YW'(cl_y0);
                  y1_ff   <= YW'(cl_y1);
               end
               OP_CIRCLE:        kind_ff <= KIND_CIRC;
               OP_PIXEL, OP_READ: kind_ff <= KIND_POINT;
               default:          kind_ff <= KIND_NONE;
            endcase
         end
      end
   end

   // walk step arithmetic
   assign x_inc    = x_ff + 1'b1;
   assign y_inc    = y_ff + 1'b1;
   assign x_wrap   = (x_inc == x1_ff);
   assign dx_end   = (dx_ff == r_s);
   assign dx2_step = {2'b00, dx2_ff} + {{7{dx_ff[7]}}, dx_ff, 1'b0} + 16'd1;
   assign dy2_step = {2'b00, dy2_ff} + {{7{dy_ff[7]}}, dy_ff, 1'b0} + 16'd1;
   assign sq_sum   = {1'b0, dx2_ff} + {1'b0, dy2_ff};
   assign hit      = (sq_sum < {1'b0, lim_ff});

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         x_ff   <= x0_ff;
         y_ff   <= y0_ff;
         dx_ff  <= (kind_ff == KIND_CIRC) ? -r_s : 8'sd0;
         dy_ff  <= (kind_ff == KIND_CIRC) ? -r_s : 8'sd0;
         dx2_ff <= rr_ff;
         dy2_ff <= rr_ff;
         lim_ff <= rr_ff + 14'(r_ff);
      end else if (cmd.scan) begin
         if (kind_ff == KIND_RECT) begin
            if (x_wrap) begin
               x_ff <= x0_ff;
               y_ff <= y_inc;
            end else begin
               x_ff <= x_inc;
            end
         end else if (kind_ff == KIND_CIRC) begin
            if (dx_end) begin
               dx_ff  <= -r_s;
               dx2_ff <= rr_ff;
               dy_ff  <= dy_ff + 8'sd1;
               dy2_ff <= dy2_step[13:0];
            end else begin
               dx_ff  <= dx_ff + 8'sd1;
               dx2_ff <= dx2_step[13:0];
            end
         end
      end
   end

   always_comb begin
      stat.empty    = 1'b0;
      stat.last     = 1'b1;
      stat.busy     = p1_v_ff || p2_v_ff || rdv_ff;
      stat.rsp_full = rsp_valid_ff && !rsp_ready;
      case (kind_ff)
         KIND_RECT: begin
            stat.empty = (x0_ff >= x1_ff) || (y0_ff >= y1_ff);
            stat.last  = x_wrap && (y_inc == y1_ff);
         end
         KIND_CIRC: begin
            stat.empty = (r_ff == '0);
            stat.last  = dx_end && (dy_ff == (r_s - 8'sd1));
         end
         KIND_POINT: begin
            stat.empty = 1'b0;
            stat.last  = 1'b1;
         end
         default: begin
            stat.empty = 1'b1;
            stat.last  = 1'b1;
         end
      endcase
   end

   // circle and single pixels land on the nearest edge pixel
   assign cx_sum = {fx_ff[COORD_W-1], fx_ff} + (COORD_W + 1)'(dx_ff);
   assign cy_sum = {fy_ff[COORD_W-1], fy_ff} + (COORD_W + 1)'(dy_ff);

   always_comb begin
      if (kind_ff == KIND_RECT) begin
         pt_x = x_ff;
         pt_y = y_ff;
      end else begin
         pt_x = XW'(clamp_coord(cx_sum, w13 - 1'b1));
         pt_y = YW'(clamp_coord(cy_sum, h13 - 1'b1));
      end
      pt_valid = cmd.scan && ((kind_ff == KIND_RECT) || (kind_ff == KIND_POINT) ||
                              ((kind_ff == KIND_CIRC) && hit));
   end

   assign w_sel    = init_mode_ff ? XW'(MAX_WIDTH) : w_eff;
   assign row_base = PW'(p1_y_ff) * PW'(w_sel);
   assign pix_addr = AW'(row_base + PW'(p1_x_ff));

   always_ff @(posedge clock) begin
      p1_x_ff    <= pt_x;
      p1_y_ff    <= pt_y;
      p1_rd_ff   <= rd_ff;
      p2_addr_ff <= pix_addr;
      p2_rd_ff   <= p1_rd_ff;
      if (rdv_ff) begin
         rd_data_ff <= ram_rdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
         rdv_ff  <= 1'b0;
      end else begin
         p1_v_ff <= pt_valid;
         p2_v_ff <= p1_v_ff;
         rdv_ff  <= p2_v_ff && p2_rd_ff;
      end
   end

   fbsf_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (p2_v_ff && !p2_rd_ff),
      .waddr (p2_addr_ff),
      .wdata (colour_ff),
      .re    (p2_v_ff && p2_rd_ff),
      .raddr (p2_addr_ff),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.respond) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         read_colour_ff <= (op_ff == OP_READ) ? rd_data_ff : '0;
         is_read_ff     <= (op_ff == OP_READ);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign read_colour = read_colour_ff;
   assign is_read     = is_read_ff;
endmodule

/* bench/framebuffer_shape_fill_core_test.sv */
`timescale 1ns / 100ps
// Self-checking bench for framebuffer_shape_fill_core: a directed table and
// random drawing phases checked against a pixel-store model. Needs fbsf_pkg,
// fbsf_req_if, fbsf_rsp_if and the block itself.
module framebuffer_shape_fill_core_test;
   import fbsf_pkg::*;

   localparam int MAX_W         = 64;
   localparam int MAX_H         = 64;
   localparam int STORE_WORDS   = MAX_W * MAX_H;
   localparam int STALL_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 12;
   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [12:0] first_x;
      logic [12:0] first_y;
      logic [12:0] second_x;
      logic [12:0] second_y;
      logic [6:0]  radius;
      logic [31:0] paint_colour;
   } draw_cmd_type;

   typedef struct packed {
      logic [31:0] read_colour;
      logic        is_read;
   } pixel_reply_type;

   typedef struct packed {
      draw_cmd_type    cmd;
      logic            typed;
      pixel_reply_type reply;
   } script_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   fbsf_req_if req_ch ();
   fbsf_rsp_if rsp_ch ();

   framebuffer_shape_fill_core #(
      .MAX_WIDTH  (MAX_W),
      .MAX_HEIGHT (MAX_H)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // model of the pixel store and the size registers
   logic [31:0]     frame_model [STORE_WORDS];
   logic [6:0]      width_reg;
   logic [6:0]      height_reg;
   pixel_reply_type pending_replies [$];
   script_row_type  directed_rows [$];
   int unsigned     fail_count   = 0;
   int unsigned     quiet_cycles = 0;
   bit              steady       = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int active_size(logic [6:0] v, int limit);
      if (v == 7'd0) return 1;
      if (int'(v) > limit) return limit;
      return int'(v);
   endfunction

   function automatic int clamp_int(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int pixel_index(int x, int y);
      int w;
      int h;
      w = active_size(width_reg, MAX_W);
      h = active_size(height_reg, MAX_H);
      return clamp_int(x, 0, w - 1) + clamp_int(y, 0, h - 1) * w;
   endfunction

   // apply one command to the model and return the reply it should give
   function automatic pixel_reply_type draw_and_predict(draw_cmd_type c);
      pixel_reply_type rep;
      int w, h, i, x, y, x0, x1, y0, y1, r, cx, cy, dx, dy;
      rep = '0;
      w = active_size(width_reg, MAX_W);
      h = active_size(height_reg, MAX_H);
      cx = int'($signed(c.first_x));
      cy = int'($signed(c.first_y));
      case (c.opcode)
         OP_FILL: begin
            for (i = 0; i < w * h; i++) frame_model[i] = c.paint_colour;
         end
         OP_CLEAR: begin
            for (i = 0; i < w * h; i++) frame_model[i] = MAGENTA;
         end
         OP_PIXEL: begin
            frame_model[pixel_index(cx, cy)] = c.paint_colour;
         end
         OP_RECT: begin
            x0 = clamp_int(cx, 0, w);
            y0 = clamp_int(cy, 0, h);
            x1 = clamp_int(int'($signed(c.second_x)), 0, w);
            y1 = clamp_int(int'($signed(c.second_y)), 0, h);
            for (y = y0; y < y1; y++)
               for (x = x0; x < x1; x++) frame_model[x + y * w] = c.paint_colour;
         end
         OP_CIRCLE: begin
            r = int'(c.radius);
            for (dy = -r; dy < r; dy++)
               for (dx = -r; dx <= r; dx++)
                  if (dx * dx + dy * dy < r * r + r)
                     frame_model[pixel_index(cx + dx, cy + dy)] = c.paint_colour;
         end
         OP_READ: begin
            rep.read_colour = frame_model[pixel_index(cx, cy)];
            rep.is_read     = 1'b1;
         end
         default: ;
      endcase
      return rep;
   endfunction

   // mostly near the visible area, now and then anywhere in the field
   function automatic logic [12:0] random_coord(int size);
      int          t;
      logic [12:0] v;
      if ($urandom_range(0, 4) == 0) begin
         v = 13'($urandom);
         return v;
      end
      t = $urandom_range(0, size + 3);
      t = t - 2;
      return t[12:0];
   endfunction

   function automatic draw_cmd_type random_command();
      draw_cmd_type c;
      int           pick;
      int           w;
      int           h;
      w = active_size(width_reg, MAX_W);
      h = active_size(height_reg, MAX_H);
      c.first_x      = random_coord(w);
      c.first_y      = random_coord(h);
      c.second_x     = random_coord(w);
      c.second_y     = random_coord(h);
      // keep most circles small, the scan time grows with the square of r
      c.radius       = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                                   : 7'($urandom_range(0, 5));
      c.paint_colour = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 4)       c.opcode = OP_FILL;
      else if (pick < 8)  c.opcode = OP_CLEAR;
      else if (pick < 30) c.opcode = OP_PIXEL;
      else if (pick < 48) c.opcode = OP_RECT;
      else if (pick < 62) c.opcode = OP_CIRCLE;
      else if (pick < 95) c.opcode = OP_READ;
      else                c.opcode = ($urandom_range(0, 1) == 0) ? OP_SPARE_A : OP_SPARE_B;
      return c;
   endfunction

   function automatic void add_row(logic [2:0] op, int fx, int fy, int sx, int sy, int r,
                                   logic [31:0] colour, int typed,
                                   logic [31:0] want_colour, int want_read);
      script_row_type row;
      row.cmd.opcode            = op;
      row.cmd.first_x           = fx[12:0];
      row.cmd.first_y           = fy[12:0];
      row.cmd.second_x          = sx[12:0];
      row.cmd.second_y          = sy[12:0];
      row.cmd.radius            = r[6:0];
      row.cmd.paint_colour      = colour;
      row.typed                 = (typed != 0);
      row.reply.read_colour     = want_colour;
      row.reply.is_read         = (want_read != 0);
      directed_rows.push_back(row);
   endfunction

   task automatic send_command(draw_cmd_type c, logic typed, pixel_reply_type typed_reply);
      pixel_reply_type predicted;
      while (!steady && $urandom_range(0, 99) < 33) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.opcode       <= c.opcode;
      req_ch.first_x      <= c.first_x;
      req_ch.first_y      <= c.first_y;
      req_ch.second_x     <= c.second_x;
      req_ch.second_y     <= c.second_y;
      req_ch.radius       <= c.radius;
      req_ch.paint_colour <= c.paint_colour;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predicted = draw_and_predict(c);
      pending_replies.push_back(typed ? typed_reply : predicted);
   endtask

   // hold off the sender until every outstanding item has been answered
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic idx, logic [6:0] value);
      logic [31:0] noise;
      noise = $urandom;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {noise[31:7], value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (idx == CSR_WIDTH) width_reg = value;
      else height_reg = value;
      @(posedge clock);
   endtask

   task automatic run_phase(logic [6:0] wv, logic [6:0] hv, int count, bit calm, int drain_at);
      int n;
      write_register(CSR_WIDTH, wv);
      write_register(CSR_HEIGHT, hv);
      steady = calm;
      for (n = 0; n < count; n++) begin
         if (n == drain_at) drain_results();
         send_command(random_command(), 1'b0, '0);
      end
      drain_results();
      steady = 1'b0;
   endtask

   always @(posedge clock) begin : check_results
      pixel_reply_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_replies.size() == 0) begin
               $error("result item arrived with no command outstanding");
               fail_count++;
            end else begin
               want = pending_replies.pop_front();
               if (rsp_ch.read_colour !== want.read_colour) begin
                  $error("read_colour: expected %08h, actual %08h",
                         want.read_colour, rsp_ch.read_colour);
                  fail_count++;
               end
               if (rsp_ch.is_read !== want.is_read) begin
                  $error("is_read: expected %0b, actual %0b", want.is_read, rsp_ch.is_read);
                  fail_count++;
               end
            end
         end
         rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 33);
      end
   end

   // count cycles in which neither channel moves an item
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int i;
      int row;
      reset               = 1'b1;
      psel                = 1'b0;
      penable             = 1'b0;
      pwrite              = 1'b0;
      paddr               = '0;
      pwdata              = '0;
      req_ch.valid        = 1'b0;
      req_ch.opcode       = OP_FILL;
      req_ch.first_x      = '0;
      req_ch.first_y      = '0;
      req_ch.second_x     = '0;
      req_ch.second_y     = '0;
      req_ch.radius       = '0;
      req_ch.paint_colour = '0;
      rsp_ch.ready        = 1'b0;
      width_reg           = SIZE_RESET;
      height_reg          = SIZE_RESET;
      for (i = 0; i < STORE_WORDS; i++) frame_model[i] = MAGENTA;

      // store is magenta after reset; far-out coordinates land on the edge
      add_row(OP_READ,      0,     0,     0,     0,   0, 32'h0,        1, MAGENTA,      1);
      add_row(OP_READ,  -4096, -4096,     0,     0,   0, 32'h0,        1, MAGENTA,      1);
      add_row(OP_READ,   4095,  4095,     0,     0,   0, 32'h0,        1, MAGENTA,      1);
      add_row(OP_PIXEL,  4095, -4096,     0,     0,   0, 32'hffffffff, 1, 32'h0,        0);
      add_row(OP_READ,     63,     0,     0,     0,   0, 32'h0,        1, 32'hffffffff, 1);
      add_row(OP_RECT,  -4096, -4096,  4095,  4095,   0, 32'h0,        1, 32'h0,        0);
      add_row(OP_READ,     10,    20,     0,     0,   0, 32'h0,        1, 32'h0,        1);
      // inverted span writes nothing
      add_row(OP_RECT,      5,     5,     2,     2,   0, 32'h12345678, 1, 32'h0,        0);
      add_row(OP_RECT,      3,     4,     7,     6,   0, 32'ha5a5a5a5, 0, 32'h0,        0);
      add_row(OP_READ,      3,     4,     0,     0,   0, 32'h0,        0, 32'h0,        0);
      add_row(OP_READ,      7,     5,     0,     0,   0, 32'h0,        0, 32'h0,        0);
      // zero radius covers no pixel
      add_row(OP_CIRCLE,   10,    10,     0,     0,   0, 32'hdeadbeef, 1, 32'h0,        0);
      add_row(OP_READ,     10,    10,     0,     0,   0, 32'h0,        1, 32'h0,        1);
      add_row(OP_CIRCLE,    0,     0,     0,     0,   1, 32'h0f0f0f0f, 0, 32'h0,        0);
      add_row(OP_READ,      0,     0,     0,     0,   0, 32'h0,        0, 32'h0,        0);
      add_row(OP_CIRCLE,   32,    32,     0,     0, 127, 32'h80000001, 0, 32'h0,        0);
      add_row(OP_READ,     63,    63,     0,     0,   0, 32'h0,        0, 32'h0,        0);
      add_row(OP_CIRCLE,   20,    30,     0,     0,   3, 32'h3c3c3c3c, 0, 32'h0,        0);
      add_row(OP_READ,     22,    31,     0,     0,   0, 32'h0,        0, 32'h0,        0);
      // spare opcodes do nothing
      add_row(OP_SPARE_A,  -1,    -1,    -1,    -1, 127, 32'hffffffff, 1, 32'h0,        0);
      add_row(OP_SPARE_B,   0,     0,     0,     0,   0, 32'h0,        1, 32'h0,        0);
      add_row(OP_FILL,      0,     0,     0,     0,   0, 32'h5a5a5a5a, 1, 32'h0,        0);
      add_row(OP_READ,     33,    17,     0,     0,   0, 32'h0,        1, 32'h5a5a5a5a, 1);
      add_row(OP_CLEAR,     0,     0,     0,     0,   0, 32'h12345678, 1, 32'h0,        0);
      add_row(OP_READ,     63,    63,     0,     0,   0, 32'h0,        1, MAGENTA,      1);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (row = 0; row < directed_rows.size(); row++)
         send_command(directed_rows[row].cmd, directed_rows[row].typed, directed_rows[row].reply);
      drain_results();

      // sizes of zero and above the maximum are clamped by the block
      run_phase(7'd1,   7'd1,   12, 1'b0, -1);
      run_phase(7'd64,  7'd1,   12, 1'b0, -1);
      run_phase(7'd1,   7'd64,  12, 1'b0, -1);
      run_phase(7'd0,   7'd0,    8, 1'b0, -1);
      run_phase(7'd7,   7'd5,   22, 1'b1, -1);
      run_phase(7'd127, 7'd9,   12, 1'b0, -1);
      run_phase(7'($urandom_range(2, 16)), 7'($urandom_range(2, 16)), 25, 1'b0, 12);
      run_phase(7'd127, 7'd127, 12, 1'b0, -1);

      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
